// ===== design/ptw_pkg.sv =====
`default_nettype none
package ptw_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_TABLE_RSP = 2'd1;
  localparam logic [1:0] OP_CHECK_RSP = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Walk status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_L1_INVALID = 3'd1;
  localparam logic [2:0] ST_L2_INVALID = 3'd2;
  localparam logic [2:0] ST_UNREADABLE = 3'd3;
  localparam logic [2:0] ST_UNBACKED   = 3'd4;

  localparam logic [31:0] MASK_4M = 32'hFFC0_0000;
  localparam logic [31:0] MASK_4K = 32'hFFFF_F000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified transaction as it travels from the front to the back.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] vaddr;
    logic [31:0] l1_addr;
    logic [31:0] base;
    logic        pte_v;
    logic        pte_leaf;
    logic        readable;
    logic        backed;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [2:0]  status;
    logic        huge_page;
    logic [31:0] va_tag;
    logic [31:0] pa_tag;
    logic [31:0] first_entry_addr;
    logic [31:0] second_entry_addr;
  } result_t;

endpackage
`default_nettype wire

// ===== design/ptw_cfg_if.sv =====
`default_nettype none
interface ptw_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ptw_cmd_if.sv =====
`default_nettype none
interface ptw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] virt_addr;
  logic [31:0] read_data;
  logic        readable;
  logic        backed;

  modport source (output valid, output op, output virt_addr, output read_data,
                  output readable, output backed, input ready);
  modport sink (input valid, input op, input virt_addr, input read_data,
                input readable, input backed, output ready);
endinterface
`default_nettype wire

// ===== design/ptw_res_if.sv =====
`default_nettype none
interface ptw_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [2:0]  status;
  logic        huge_page;
  logic [31:0] va_tag;
  logic [31:0] pa_tag;
  logic [31:0] first_entry_addr;
  logic [31:0] second_entry_addr;

  modport source (output valid, output kind, output address, output status,
                  output huge_page, output va_tag, output pa_tag,
                  output first_entry_addr, output second_entry_addr, input ready);
  modport sink (input valid, input kind, input address, input status,
                input huge_page, input va_tag, input pa_tag,
                input first_entry_addr, input second_entry_addr, output ready);
endinterface
`default_nettype wire

// ===== design/ptw_front.sv =====
`default_nettype none
module ptw_front (
  input  wire logic           clk,
  input  wire logic           rst,
  ptw_cfg_if.sink             cfg,
  ptw_cmd_if.sink             cmd,
  input  wire logic           q_ready,
  output logic                push,
  output ptw_pkg::entry_t     entry
);
  import ptw_pkg::*;

  logic [19:0] root_page_number;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page_number <= '0;
    end else if (cfg.valid) begin
      root_page_number <= cfg.data;
    end
  end

  assign cmd.ready = q_ready;
  assign push      = cmd.valid && q_ready;

  // The root entry address and the entry fields are formed here so the back
  // only has to decide and select.
  always_comb begin
    entry.op       = cmd.op;
    entry.vaddr    = cmd.virt_addr;
    entry.l1_addr  = {root_page_number, 12'h000} + {20'h00000, cmd.virt_addr[31:22], 2'b00};
    entry.base     = {cmd.read_data[31:10], 10'h000} << 2;
    entry.pte_v    = cmd.read_data[0];
    entry.pte_leaf = (cmd.read_data[3:1] != 3'b000);
    entry.readable = cmd.readable;
    entry.backed   = cmd.backed;
  end

endmodule
`default_nettype wire

// ===== design/ptw_queue.sv =====
`default_nettype none
module ptw_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ptw_pkg::entry_t  push_entry,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output ptw_pkg::entry_t       head
);
  import ptw_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign not_full  = (count != QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> not_full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== design/ptw_back.sv =====
`default_nettype none
module ptw_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire ptw_pkg::entry_t  q_entry,
  output logic                  pop,
  ptw_res_if.source             res
);
  import ptw_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_L1,
    PH_L2,
    PH_CHECK
  } phase_t;

  phase_t      phase;
  logic [31:0] saved_vaddr;
  logic [31:0] level1_addr;
  logic [31:0] level2_addr;
  logic [31:0] leaf_phys;
  logic        is_huge;
  logic        res_valid;
  result_t     res_data;

  phase_t      phase_next;
  logic [31:0] saved_vaddr_next;
  logic [31:0] level1_addr_next;
  logic [31:0] level2_addr_next;
  logic [31:0] leaf_phys_next;
  logic        is_huge_next;
  logic        res_valid_next;
  result_t     res_data_next;

  logic        advance;
  logic [31:0] l2_addr;
  logic [31:0] leaf_page;

  assign advance   = !res_valid || res.ready;
  assign pop       = q_valid && advance;
  assign l2_addr   = q_entry.base + {20'h00000, saved_vaddr[21:12], 2'b00};
  assign leaf_page = q_entry.base & ((phase == PH_L1) ? MASK_4M : MASK_4K);

  always_comb begin
    phase_next       = phase;
    saved_vaddr_next = saved_vaddr;
    level1_addr_next = level1_addr;
    level2_addr_next = level2_addr;
    leaf_phys_next   = leaf_phys;
    is_huge_next     = is_huge;
    res_valid_next   = res_valid;
    res_data_next    = res_data;
    if (advance) begin
      res_valid_next = 1'b0;
      if (q_valid) begin
        case (q_entry.op)
          OP_TRANSLATE: begin
            saved_vaddr_next      = q_entry.vaddr;
            level1_addr_next      = q_entry.l1_addr;
            level2_addr_next      = '0;
            leaf_phys_next        = '0;
            is_huge_next          = 1'b0;
            phase_next            = PH_L1;
            res_valid_next        = 1'b1;
            res_data_next         = '0;
            res_data_next.kind    = KIND_READ;
            res_data_next.address = q_entry.l1_addr;
          end
          OP_TABLE_RSP: begin
            if (phase == PH_L1 || phase == PH_L2) begin
              res_valid_next = 1'b1;
              res_data_next  = '0;
              if (!q_entry.readable) begin
                phase_next           = PH_IDLE;
                res_data_next.kind   = KIND_DONE;
                res_data_next.status = ST_UNREADABLE;
              end else if (!q_entry.pte_v) begin
                phase_next           = PH_IDLE;
                res_data_next.kind   = KIND_DONE;
                res_data_next.status = (phase == PH_L1) ? ST_L1_INVALID : ST_L2_INVALID;
              end else if (phase == PH_L1 && !q_entry.pte_leaf) begin
                level2_addr_next      = l2_addr;
                phase_next            = PH_L2;
                res_data_next.kind    = KIND_READ;
                res_data_next.address = l2_addr;
              end else begin
                is_huge_next          = (phase == PH_L1);
                leaf_phys_next        = leaf_page;
                phase_next            = PH_CHECK;
                res_data_next.kind    = KIND_CHECK;
                res_data_next.address = leaf_page;
              end
            end
          end
          OP_CHECK_RSP: begin
            if (phase == PH_CHECK) begin
              phase_next         = PH_IDLE;
              res_valid_next     = 1'b1;
              res_data_next      = '0;
              res_data_next.kind = KIND_DONE;
              if (!q_entry.backed) begin
                res_data_next.status = ST_UNBACKED;
              end else begin
                res_data_next.huge_page         = is_huge;
                res_data_next.va_tag            = saved_vaddr & (is_huge ? MASK_4M : MASK_4K);
                res_data_next.pa_tag            = leaf_phys;
                res_data_next.first_entry_addr  = level1_addr;
                res_data_next.second_entry_addr = is_huge ? 32'h0 : level2_addr;
              end
            end
          end
          default: begin
            // Unused operation code: dropped without effect.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      saved_vaddr <= '0;
      level1_addr <= '0;
      level2_addr <= '0;
      leaf_phys   <= '0;
      is_huge     <= 1'b0;
      res_valid   <= 1'b0;
      res_data    <= '0;
    end else begin
      phase       <= phase_next;
      saved_vaddr <= saved_vaddr_next;
      level1_addr <= level1_addr_next;
      level2_addr <= level2_addr_next;
      leaf_phys   <= leaf_phys_next;
      is_huge     <= is_huge_next;
      res_valid   <= res_valid_next;
      res_data    <= res_data_next;
    end
  end

  assign res.valid             = res_valid;
  assign res.kind              = res_data.kind;
  assign res.address           = res_data.address;
  assign res.status            = res_data.status;
  assign res.huge_page         = res_data.huge_page;
  assign res.va_tag            = res_data.va_tag;
  assign res.pa_tag            = res_data.pa_tag;
  assign res.first_entry_addr  = res_data.first_entry_addr;
  assign res.second_entry_addr = res_data.second_entry_addr;

  a_translate_reads: assert property (@(posedge clk) disable iff (rst)
    (pop && q_entry.op == OP_TRANSLATE) |=>
      (res_valid && res_data.kind == KIND_READ && phase == PH_L1))
    else $error("translate request did not issue a root entry read");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status != ST_OK) |->
      (res_data.kind == KIND_DONE && res_data.va_tag == 32'h0 &&
       res_data.pa_tag == 32'h0 && !res_data.huge_page))
    else $error("failed walk carries nonzero tags");

endmodule
`default_nettype wire

// ===== design/sv32_page_table_walker_top.sv =====
`default_nettype none
// Sv32 two-level page table walker. Requests and memory responses share one
// command channel: a translate request (op 0) starts a walk and produces a
// table read transaction for the root entry, table read responses (op 1)
// lead to a second read, a region check or a failure status, and the
// region check response (op 2) finishes the walk with the tags, the page
// size and both entry addresses, or with a failure status. A new translate
// request abandons any walk in flight, and responses that do not fit the
// current phase are dropped without a result. The command channel takes
// one transaction every clock cycle while the queue has room; each accepted
// transaction passes through the two-entry queue between the classifying
// front and the walking back, then through the output register, before its
// result, if any, appears. The queue lets the block keep taking commands
// while a result waits; under a stalled result the queue fills and the
// command channel drops ready after two more transactions. The root page
// number is written through the configuration channel, which is always
// ready, and must only be changed while no walk is pending.
module sv32_page_table_walker_top (
  input  wire logic clk,
  input  wire logic rst,
  ptw_cfg_if.sink   cfg,
  ptw_cmd_if.sink   cmd,
  ptw_res_if.source res
);
  import ptw_pkg::*;

  logic   push;
  logic   pop;
  logic   q_not_full;
  logic   q_not_empty;
  entry_t push_entry;
  entry_t head;

  // Front: holds the root page number, accepts commands and precomputes the
  // root entry address and the decoded entry fields.
  ptw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .q_ready (q_not_full),
    .push    (push),
    .entry   (push_entry)
  );

  // Short queue so the front and the back can stall independently.
  ptw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  // Back: the walk state machine and the registered result.
  ptw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_entry (head),
    .pop     (pop),
    .res     (res)
  );

endmodule
`default_nettype wire
